FILE: rtl/rmai_pkg.sv
// Package for the register-machine ALU interpreter.
// Types, opcodes, actions, sequencer states and bit helpers; no dependencies.
package rmai_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  reg_select;
    logic [63:0] load_value;
    logic [15:0] instruction;
    logic        end_of_program;
  } rmai_req_t;

  typedef struct packed {
    logic [2:0]  dest_index;
    logic [63:0] dest_value;
    logic        done_res;
  } rmai_res_t;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_EXEC = 2'd1;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_XOR = 4'd2;
  localparam logic [3:0] OP_SHL = 4'd3;
  localparam logic [3:0] OP_SHR = 4'd4;
  localparam logic [3:0] OP_EOR = 4'd5;
  localparam logic [3:0] OP_POP = 4'd6;
  localparam logic [3:0] OP_CLZ = 4'd7;
  localparam logic [3:0] OP_SWP = 4'd8;
  localparam logic [3:0] OP_REV = 4'd9;
  localparam logic [3:0] OP_ROL = 4'd10;
  localparam logic [3:0] OP_MIL = 4'd11;
  localparam logic [3:0] OP_MUL = 4'd12;
  localparam logic [3:0] OP_DUV = 4'd13;
  localparam logic [3:0] OP_DIV = 4'd14;
  localparam logic [3:0] OP_CMP = 4'd15;

  localparam logic [63:0] M1 = 64'h5555555555555555;
  localparam logic [63:0] M2 = 64'h3333333333333333;
  localparam logic [63:0] M4 = 64'h0F0F0F0F0F0F0F0F;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MUL, ST_DIV, ST_FIX, ST_DONE
  } rmai_state_t;

  // Control from sequencer to the shared unit
  typedef struct packed {
    logic start_mul;
    logic start_div;
    logic is_signed;
    logic low_only;
  } rmai_ctl_t;

  function automatic logic [6:0] pop64(input logic [63:0] x);
    logic [63:0] y;
    y = x - ((x >> 1) & M1);
    y = (y & M2) + ((y >> 2) & M2);
    y = (y + (y >> 4)) & M4;
    pop64 = 7'(y[7:0]) + 7'(y[15:8]) + 7'(y[23:16]) + 7'(y[31:24])
          + 7'(y[39:32]) + 7'(y[47:40]) + 7'(y[55:48]) + 7'(y[63:56]);
  endfunction

  function automatic logic [6:0] clz64(input logic [63:0] x);
    logic [63:0] y;
    logic [6:0]  n;
    y = x;
    n = 7'd0;
    if (x == 64'd0) begin
      n = 7'd64;
    end else begin
      if (y[63:32] == 32'd0) begin n = n + 7'd32; y = y << 32; end
      if (y[63:48] == 16'd0) begin n = n + 7'd16; y = y << 16; end
      if (y[63:56] == 8'd0) begin n = n + 7'd8; y = y << 8; end
      if (y[63:60] == 4'd0) begin n = n + 7'd4; y = y << 4; end
      if (y[63:62] == 2'd0) begin n = n + 7'd2; y = y << 2; end
      if (y[63] == 1'b0) begin n = n + 7'd1; end
    end
    clz64 = n;
  endfunction

endpackage

FILE: rtl/rmai_muldiv.sv
// Shared iterative multiply / divide unit for the interpreter.
// Radix-2: one bit per cycle. Uses rmai_pkg.
module rmai_muldiv import rmai_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rmai_ctl_t   ctl,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic        busy,
  output logic [63:0] res
);

  logic [6:0]   count;
  logic         mode_div;
  logic         mode_low;
  logic         neg_q;
  logic         neg_r;
  logic [127:0] acc;
  logic [64:0]  acc_sum;
  logic [63:0]  mcand;
  logic [64:0]  rem;
  logic [63:0]  quo;
  logic [63:0]  dvsr;
  logic [63:0]  dvsr_in;
  logic [64:0]  rem_shift;
  logic [64:0]  rem_sub;
  logic [63:0]  q_fix;
  logic [63:0]  r_fix;

  // divisor is always a|1
  assign dvsr_in   = op_a | 64'd1;
  assign rem_shift = {rem[63:0], quo[63]};
  assign rem_sub   = rem_shift - {1'b0, dvsr};
  assign acc_sum   = {1'b0, acc[127:64]} + (acc[0] ? {1'b0, mcand} : 65'd0);

  // Result forming: product fold, low product half, or signed quotient plus remainder
  always_comb begin
    q_fix = neg_q ? (64'd0 - quo) : quo;
    r_fix = neg_r ? (64'd0 - rem[63:0]) : rem[63:0];
    if (mode_div) begin
      res = q_fix + r_fix;
    end else if (mode_low) begin
      res = acc[63:0];
    end else begin
      res = acc[127:64] + acc[63:0];
    end
  end

  assign busy = (count != 7'd0);

  // One shift-add or restoring subtract step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 7'd0;
    end else if (ctl.start_mul) begin
      count    <= 7'd64;
      mode_div <= 1'b0;
      mode_low <= ctl.low_only;
      acc      <= {64'd0, op_b};
      mcand    <= op_a;
    end else if (ctl.start_div) begin
      count    <= 7'd64;
      mode_div <= 1'b1;
      neg_q    <= ctl.is_signed & (op_b[63] ^ dvsr_in[63]);
      neg_r    <= ctl.is_signed & op_b[63];
      quo      <= (ctl.is_signed & op_b[63]) ? (64'd0 - op_b) : op_b;
      dvsr     <= (ctl.is_signed & dvsr_in[63]) ? (64'd0 - dvsr_in) : dvsr_in;
      rem      <= 65'd0;
    end else if (busy) begin
      count <= count - 7'd1;
      if (mode_div) begin
        if (!rem_sub[64]) begin
          rem <= rem_sub;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[62:0], 1'b0};
        end
      end else begin
        acc <= {acc_sum, acc[63:1]};
      end
    end
  end

endmodule

FILE: rtl/register_machine_alu_interpreter.sv
// Register-machine ALU interpreter: register file, sequencer, single-cycle ops.
// Depends on rmai_pkg and rmai_muldiv.
// Load, read and single-cycle ops pass through read and result; multiply/divide
// pass through read, the 64-step shared unit, fix and result.
// Throughput: one request at a time, next taken the cycle after the result
// leaves.
// Sync reset clears all eight registers and the sequencer.
module register_machine_alu_interpreter import rmai_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  rmai_req_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output rmai_res_t out_data
);

  logic [63:0] regs [8];
  rmai_state_t state, state_next;
  rmai_req_t   req;
  rmai_ctl_t   ctl;
  logic [63:0] a, b, alu, mres;
  logic        mbusy;
  logic [3:0]  op;
  logic [5:0]  imm;
  logic [2:0]  ra, rb;
  logic        flag;
  logic [63:0] sw, t;
  logic [63:0] wr_val;
  logic        wr_en;

  assign op  = req.instruction[3:0];
  assign imm = req.instruction[15:10];
  assign rb  = req.instruction[9:7];
  assign ra  = (req.instruction[6:4] == rb) ? rb + 3'd1 : req.instruction[6:4];

  // Operand read from the register file
  assign a = regs[ra];
  assign b = regs[rb];

  rmai_muldiv u_md (
    .clk(clk), .rst(rst), .ctl(ctl), .op_a(a), .op_b(b), .busy(mbusy), .res(mres)
  );

  // Single-cycle operations
  always_comb begin
    flag = 1'b0;
    case (imm[2:0])
      3'd0: flag = b < a;
      3'd1: flag = b > a;
      3'd2: flag = b[3:0] == 4'd0;
      3'd3: flag = a[3:0] == 4'd0;
      3'd4: flag = b[3:0] == a[3:0];
      3'd5: flag = $signed(b) < $signed(a);
      3'd6: flag = a[63];
      default: flag = b[63];
    endcase
    for (int i = 0; i < 8; i++) sw[i*8 +: 8] = b[(7-i)*8 +: 8];
    for (int i = 0; i < 64; i++) t[i] = b[63-i];
    case (op)
      OP_ADD:  alu = b + a;
      OP_SUB:  alu = b - a;
      OP_XOR:  alu = b ^ a;
      OP_SHL:  alu = b + (a << imm);
      OP_SHR:  alu = b + (a >> imm);
      OP_EOR:  alu = b + (a ^ {58'd0, imm});
      OP_POP:  alu = b + {57'd0, pop64(a)};
      OP_CLZ:  alu = b + {57'd0, clz64(a)};
      OP_SWP:  alu = sw;
      OP_REV:  alu = t;
      OP_ROL:  alu = (imm == 6'd0) ? b : ((b << imm) | (b >> (7'd64 - {1'b0, imm})));
      OP_MIL:  alu = b;
      OP_MUL:  alu = b;
      OP_DUV:  alu = b;
      OP_DIV:  alu = b;
      default: alu = b + {63'd0, flag};
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_READ;
      ST_READ: begin
        if (req.action == ACT_EXEC && (op == OP_MUL || op == OP_MIL))
          state_next = ST_MUL;
        else if (req.action == ACT_EXEC && (op == OP_DUV || op == OP_DIV))
          state_next = ST_DIV;
        else
          state_next = ST_DONE;
      end
      ST_MUL: if (!mbusy) state_next = ST_FIX;
      ST_DIV: if (!mbusy) state_next = ST_FIX;
      ST_FIX: state_next = ST_DONE;
      ST_DONE: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = (state == ST_IDLE);
    out_valid     = (state == ST_DONE);
    ctl.start_mul = (state == ST_READ) && req.action == ACT_EXEC
                    && (op == OP_MUL || op == OP_MIL);
    ctl.start_div = (state == ST_READ) && req.action == ACT_EXEC
                    && (op == OP_DUV || op == OP_DIV);
    ctl.is_signed = (op == OP_DIV);
    ctl.low_only  = (op == OP_MIL);
    wr_en  = 1'b0;
    wr_val = alu;
    if (state == ST_READ && req.action == ACT_LOAD) begin
      wr_en = 1'b1; wr_val = req.load_value;
    end else if (state == ST_READ && req.action == ACT_EXEC && !ctl.start_mul
                 && !ctl.start_div) begin
      wr_en = 1'b1;
    end else if (state == ST_FIX) begin
      wr_en = 1'b1;
      wr_val = b + mres;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < 8; i++) regs[i] <= 64'd0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) req <= in_data;
      if (wr_en) begin
        regs[(req.action == ACT_EXEC) ? rb : req.reg_select] <= wr_val;
      end
      if (state == ST_READ) begin
        out_data.dest_index <= (req.action == ACT_EXEC) ? rb : req.reg_select;
        out_data.dest_value <= (req.action == ACT_EXEC || req.action == ACT_LOAD)
                               ? wr_val : regs[req.reg_select];
        out_data.done_res   <= (req.action == ACT_EXEC) & req.end_of_program;
      end else if (state == ST_FIX) begin
        out_data.dest_value <= wr_val;
      end
    end
  end

  a_one_hs: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("in and out both open");
  a_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIX |=> out_valid) else $error("fix not followed by result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");

endmodule
